### src/esw_pkg.sv
// shared types and constants of the edge swap engine
package esw_pkg;

    localparam int NODE_W       = 8;
    localparam int IDX_W        = 10;
    localparam int EDGES_W      = 11;
    localparam int EXCL_CNT_W   = 5;
    localparam int CNT_W        = 32;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int MAX_EDGES    = 1024;
    localparam int MAX_EXCLUDED = 16;
    localparam int EXCL_AW      = 4;
    localparam int SUM_W        = 9;
    localparam int CODE_W       = 17;
    localparam int EDGE_W       = 2 * NODE_W;
    // pair code of (255,255) plus one
    localparam int BITMAP_BITS  = 130561;

    typedef enum logic [1:0] {
        OP_LOAD_EDGE = 2'd0,
        OP_LOAD_EXCL = 2'd1,
        OP_SWAP      = 2'd2,
        OP_READ      = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        OUT_SWAPPED = 3'd0,
        OUT_SAME    = 3'd1,
        OUT_SELF    = 3'd2,
        OUT_DUP     = 3'd3,
        OUT_REV     = 3'd4,
        OUT_EXCL    = 3'd5,
        OUT_DONE    = 3'd6,
        OUT_BAD     = 3'd7
    } outcome_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EDGES_IN_USE    = 2'd0,
        REG_EXCLUDED_IN_USE = 2'd1,
        REG_DIRECTED_MODE   = 2'd2
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_LOAD_SET,
        S_READ_WAIT,
        S_SW_RDA,
        S_SW_RDB,
        S_CHK,
        S_CHK_DUP1,
        S_CHK_DUP2,
        S_CHK_REV,
        S_EX_START,
        S_EX_CMP,
        S_NEXT,
        S_SW_P1,
        S_SW_C1,
        S_SW_C2,
        S_SW_S1,
        S_SW_S2,
        S_RESP
    } state_t;

endpackage

### src/esw_if.sv
// handshake channels of the edge swap engine
interface esw_item_if
    import esw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        operation;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [NODE_W-1:0] source_node;
    logic [NODE_W-1:0] target_node;

    modport source (output valid, operation, index_a, index_b, source_node, target_node,
                    input ready);
    modport sink (input valid, operation, index_a, index_b, source_node, target_node,
                  output ready);
endinterface

interface esw_result_if
    import esw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        outcome;
    logic [NODE_W-1:0] edge_source;
    logic [NODE_W-1:0] edge_target;
    logic [CNT_W-1:0]  count_same_edge;
    logic [CNT_W-1:0]  count_self_loop;
    logic [CNT_W-1:0]  count_duplicate;
    logic [CNT_W-1:0]  count_reverse_duplicate;
    logic [CNT_W-1:0]  count_excluded;

    modport source (output valid, outcome, edge_source, edge_target, count_same_edge,
                    count_self_loop, count_duplicate, count_reverse_duplicate,
                    count_excluded, input ready);
    modport sink (input valid, outcome, edge_source, edge_target, count_same_edge,
                  count_self_loop, count_duplicate, count_reverse_duplicate,
                  count_excluded, output ready);
endinterface

interface esw_cfg_if
    import esw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### src/esw_ram.sv
// generic single port ram with registered read
module esw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                          wdata,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### src/esw_pair.sv
// shared pair code unit: (s+t)(s+t+1)/2+t, registered output
module esw_pair
    import esw_pkg::*;
(
    input  logic              clk,
    input  logic [NODE_W-1:0] s,
    input  logic [NODE_W-1:0] t,
    output logic [CODE_W-1:0] code_reg
);

    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    sum_inc;
    logic [2*SUM_W-1:0]  prod;
    logic [CODE_W-1:0]   code_next;

    // triangular number plus target
    always_comb
    begin
        sum       = SUM_W'(s) + SUM_W'(t);
        sum_inc   = sum + SUM_W'(1);
        prod      = (2*SUM_W)'(sum) * (2*SUM_W)'(sum_inc);
        code_next = CODE_W'(prod >> 1) + CODE_W'(t);
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

endmodule

### src/edge_swap_engine_top.sv
// top level of the edge swap engine: sequencer, tables and counters
// One item at a time. After reset the presence bitmap is swept clear, one bit per
// cycle, before the first item is taken (configuration writes are taken at any
// time). A load edge also sets its bitmap bit, a read waits for the edge table, and
// a swap reads both edges, checks each new edge for a self loop, a duplicate, a
// reverse duplicate (undirected mode only) and the excluded entries in use, then
// commits. The sequencing is set by the single port presence bitmap, which takes
// one lookup or update per cycle through the shared pair code unit, and by the
// one-entry-per-cycle scan of the excluded list. A finished result waits in an
// output register, so the next item is taken while it is still unread.
module edge_swap_engine_top
    import esw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    esw_cfg_if.sink    cfg,
    esw_item_if.sink   item,
    esw_result_if.source result
);

    state_t state_reg, state_next;

    logic [CODE_W-1:0]     clr_reg, clr_next;
    op_t                   op_reg, op_next;
    logic [IDX_W-1:0]      ia_reg, ia_next, ib_reg, ib_next;
    logic [NODE_W-1:0]     sn_reg, sn_next, tn_reg, tn_next;
    logic [NODE_W-1:0]     sa_reg, sa_next, ta_reg, ta_next;
    logic [NODE_W-1:0]     sb_reg, sb_next, tb_reg, tb_next;
    logic                  cand_reg, cand_next;
    logic [EXCL_CNT_W-1:0] xidx_reg, xidx_next;
    outcome_t              outcome_reg, outcome_next;
    logic [NODE_W-1:0]     rs_reg, rs_next, rt_reg, rt_next;

    logic [CNT_W-1:0] cnt_same_reg, cnt_self_reg, cnt_dup_reg, cnt_rev_reg, cnt_excl_reg;
    logic [CNT_W-1:0] cnt_same_next, cnt_self_next, cnt_dup_next, cnt_rev_next;
    logic [CNT_W-1:0] cnt_excl_next;

    logic [EDGES_W-1:0]    eu_reg;
    logic [EXCL_CNT_W-1:0] xu_reg;
    logic                  dir_reg;

    logic              res_valid_reg, res_valid_next;
    outcome_t          res_outcome_reg;
    logic [NODE_W-1:0] res_src_reg, res_tgt_reg;
    logic [CNT_W-1:0]  res_same_reg, res_self_reg, res_dup_reg, res_rev_reg, res_excl_reg;

    // memory and unit controls
    logic                  edge_we;
    logic [IDX_W-1:0]      edge_addr;
    logic [EDGE_W-1:0]     edge_wdata, edge_rdata;
    logic                  excl_we;
    logic [EXCL_AW-1:0]    excl_addr;
    logic [EDGE_W-1:0]     excl_wdata, excl_rdata;
    logic                  bm_we;
    logic [CODE_W-1:0]     bm_addr;
    logic                  bm_wdata, bm_rdata;
    logic [NODE_W-1:0]     pair_s, pair_t;
    logic [CODE_W-1:0]     pair_code;

    logic              ia_ok, ib_ok, ix_ok, res_free, excl_hit, scan_last;
    logic [NODE_W-1:0] cand_s, cand_t;
    logic [EXCL_CNT_W-1:0] xidx_inc;

    esw_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .addr  (edge_addr),
        .wdata (edge_wdata),
        .rdata (edge_rdata)
    );

    esw_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EXCLUDED)) u_excl_ram (
        .clk   (clk),
        .we    (excl_we),
        .addr  (excl_addr),
        .wdata (excl_wdata),
        .rdata (excl_rdata)
    );

    esw_ram #(.WIDTH(1), .DEPTH(BITMAP_BITS)) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .addr  (bm_addr),
        .wdata (bm_wdata),
        .rdata (bm_rdata)
    );

    esw_pair u_pair (
        .clk      (clk),
        .s        (pair_s),
        .t        (pair_t),
        .code_reg (pair_code)
    );

    // range checks and current candidate edge
    always_comb
    begin
        ia_ok     = {1'b0, ia_reg} < eu_reg;
        ib_ok     = {1'b0, ib_reg} < eu_reg;
        ix_ok     = {1'b0, ia_reg} < {{(EDGES_W-EXCL_CNT_W){1'b0}}, xu_reg};
        res_free  = !res_valid_reg || result.ready;
        cand_s    = cand_reg ? sb_reg : sa_reg;
        cand_t    = cand_reg ? ta_reg : tb_reg;
        excl_hit  = (excl_rdata[EDGE_W-1:NODE_W] == cand_s)
                    && (excl_rdata[NODE_W-1:0] == cand_t);
        xidx_inc  = xidx_reg + EXCL_CNT_W'(1);
        scan_last = xidx_inc == xu_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == CODE_W'(BITMAP_BITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_LOAD_EDGE: state_next = ia_ok ? S_LOAD_SET : S_RESP;
                    OP_LOAD_EXCL: state_next = S_RESP;
                    OP_READ:      state_next = ia_ok ? S_READ_WAIT : S_RESP;
                    OP_SWAP:      state_next = (ia_ok && ib_ok && ia_reg != ib_reg)
                                               ? S_SW_RDA : S_RESP;
                    default:      state_next = S_RESP;
                endcase
            end
            S_LOAD_SET:  state_next = S_RESP;
            S_READ_WAIT: state_next = S_RESP;
            S_SW_RDA:    state_next = S_SW_RDB;
            S_SW_RDB:    state_next = S_CHK;
            S_CHK:       state_next = (cand_s == cand_t) ? S_RESP : S_CHK_DUP1;
            S_CHK_DUP1:  state_next = S_CHK_DUP2;
            S_CHK_DUP2:
            begin
                if (bm_rdata)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = dir_reg ? S_EX_START : S_CHK_REV;
                end
            end
            S_CHK_REV:   state_next = bm_rdata ? S_RESP : S_EX_START;
            S_EX_START:  state_next = (xu_reg == '0) ? S_NEXT : S_EX_CMP;
            S_EX_CMP:
            begin
                if (excl_hit)
                begin
                    state_next = S_RESP;
                end
                else if (scan_last)
                begin
                    state_next = S_NEXT;
                end
            end
            S_NEXT:      state_next = cand_reg ? S_SW_P1 : S_CHK;
            S_SW_P1:     state_next = S_SW_C1;
            S_SW_C1:     state_next = S_SW_C2;
            S_SW_C2:     state_next = S_SW_S1;
            S_SW_S1:     state_next = S_SW_S2;
            S_SW_S2:     state_next = S_RESP;
            S_RESP:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // memory, pair unit and handshake controls
    always_comb
    begin
        item.ready = (state_reg == S_IDLE);
        edge_we    = 1'b0;
        edge_addr  = ia_reg;
        edge_wdata = {sn_reg, tn_reg};
        excl_we    = 1'b0;
        excl_addr  = ia_reg[EXCL_AW-1:0];
        excl_wdata = {sn_reg, tn_reg};
        bm_we      = 1'b0;
        bm_addr    = pair_code;
        bm_wdata   = 1'b0;
        pair_s     = cand_s;
        pair_t     = cand_t;
        unique case (state_reg)
            S_CLEAR:
            begin
                bm_we   = 1'b1;
                bm_addr = clr_reg;
            end
            S_DISPATCH:
            begin
                pair_s = sn_reg;
                pair_t = tn_reg;
                if (op_reg == OP_LOAD_EDGE && ia_ok)
                begin
                    edge_we = 1'b1;
                end
                if (op_reg == OP_LOAD_EXCL && ix_ok)
                begin
                    excl_we = 1'b1;
                end
            end
            S_LOAD_SET:
            begin
                bm_we    = 1'b1;
                bm_wdata = 1'b1;
            end
            S_SW_RDA:
            begin
                edge_addr = ib_reg;
            end
            S_CHK_DUP1:
            begin
                pair_s = cand_t;
                pair_t = cand_s;
            end
            S_EX_START:
            begin
                excl_addr = '0;
            end
            S_EX_CMP:
            begin
                excl_addr = xidx_inc[EXCL_AW-1:0];
            end
            S_SW_P1:
            begin
                pair_s = sa_reg;
                pair_t = ta_reg;
            end
            S_SW_C1:
            begin
                bm_we      = 1'b1;
                pair_s     = sb_reg;
                pair_t     = tb_reg;
                edge_we    = 1'b1;
                edge_wdata = {sa_reg, tb_reg};
            end
            S_SW_C2:
            begin
                bm_we      = 1'b1;
                pair_s     = sa_reg;
                pair_t     = tb_reg;
                edge_we    = 1'b1;
                edge_addr  = ib_reg;
                edge_wdata = {sb_reg, ta_reg};
            end
            S_SW_S1:
            begin
                bm_we    = 1'b1;
                bm_wdata = 1'b1;
                pair_s   = sb_reg;
                pair_t   = ta_reg;
            end
            S_SW_S2:
            begin
                bm_we    = 1'b1;
                bm_wdata = 1'b1;
            end
            default:
            begin
                bm_we = 1'b0;
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        clr_next       = clr_reg;
        op_next        = op_reg;
        ia_next        = ia_reg;
        ib_next        = ib_reg;
        sn_next        = sn_reg;
        tn_next        = tn_reg;
        sa_next        = sa_reg;
        ta_next        = ta_reg;
        sb_next        = sb_reg;
        tb_next        = tb_reg;
        cand_next      = cand_reg;
        xidx_next      = xidx_reg;
        outcome_next   = outcome_reg;
        rs_next        = rs_reg;
        rt_next        = rt_reg;
        cnt_same_next  = cnt_same_reg;
        cnt_self_next  = cnt_self_reg;
        cnt_dup_next   = cnt_dup_reg;
        cnt_rev_next   = cnt_rev_reg;
        cnt_excl_next  = cnt_excl_reg;
        res_valid_next = res_valid_reg && !result.ready;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + CODE_W'(1);
            end
            S_IDLE:
            begin
                op_next = op_t'(item.operation);
                ia_next = item.index_a;
                ib_next = item.index_b;
                sn_next = item.source_node;
                tn_next = item.target_node;
            end
            S_DISPATCH:
            begin
                rs_next   = '0;
                rt_next   = '0;
                cand_next = 1'b0;
                unique case (op_reg)
                    OP_LOAD_EDGE: outcome_next = ia_ok ? OUT_DONE : OUT_BAD;
                    OP_LOAD_EXCL: outcome_next = ix_ok ? OUT_DONE : OUT_BAD;
                    OP_READ:      outcome_next = ia_ok ? OUT_DONE : OUT_BAD;
                    OP_SWAP:
                    begin
                        if (!ia_ok || !ib_ok)
                        begin
                            outcome_next = OUT_BAD;
                        end
                        else if (ia_reg == ib_reg)
                        begin
                            outcome_next = OUT_SAME;
                        end
                        else
                        begin
                            outcome_next = OUT_SWAPPED;
                        end
                    end
                    default:      outcome_next = OUT_BAD;
                endcase
            end
            S_READ_WAIT:
            begin
                rs_next = edge_rdata[EDGE_W-1:NODE_W];
                rt_next = edge_rdata[NODE_W-1:0];
            end
            S_SW_RDA:
            begin
                sa_next = edge_rdata[EDGE_W-1:NODE_W];
                ta_next = edge_rdata[NODE_W-1:0];
            end
            S_SW_RDB:
            begin
                sb_next = edge_rdata[EDGE_W-1:NODE_W];
                tb_next = edge_rdata[NODE_W-1:0];
            end
            S_CHK:
            begin
                if (cand_s == cand_t)
                begin
                    outcome_next = OUT_SELF;
                end
            end
            S_CHK_DUP2:
            begin
                if (bm_rdata)
                begin
                    outcome_next = OUT_DUP;
                end
            end
            S_CHK_REV:
            begin
                if (bm_rdata)
                begin
                    outcome_next = OUT_REV;
                end
            end
            S_EX_START:
            begin
                xidx_next = '0;
            end
            S_EX_CMP:
            begin
                if (excl_hit)
                begin
                    outcome_next = OUT_EXCL;
                end
                xidx_next = xidx_inc;
            end
            S_NEXT:
            begin
                cand_next = 1'b1;
            end
            S_RESP:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    unique case (outcome_reg)
                        OUT_SAME: cnt_same_next = cnt_same_reg + CNT_W'(1);
                        OUT_SELF: cnt_self_next = cnt_self_reg + CNT_W'(1);
                        OUT_DUP:  cnt_dup_next  = cnt_dup_reg + CNT_W'(1);
                        OUT_REV:  cnt_rev_next  = cnt_rev_reg + CNT_W'(1);
                        OUT_EXCL: cnt_excl_next = cnt_excl_reg + CNT_W'(1);
                        default:  cnt_same_next = cnt_same_reg;
                    endcase
                end
            end
            default:
            begin
                clr_next = clr_reg;
            end
        endcase
    end

    // control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
            cnt_same_reg  <= '0;
            cnt_self_reg  <= '0;
            cnt_dup_reg   <= '0;
            cnt_rev_reg   <= '0;
            cnt_excl_reg  <= '0;
            eu_reg        <= '0;
            xu_reg        <= '0;
            dir_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_valid_reg <= res_valid_next;
            cnt_same_reg  <= cnt_same_next;
            cnt_self_reg  <= cnt_self_next;
            cnt_dup_reg   <= cnt_dup_next;
            cnt_rev_reg   <= cnt_rev_next;
            cnt_excl_reg  <= cnt_excl_next;
            // config word; counts saturate to table sizes, excluded from data[4:0]
            if (cfg.valid)
            begin
                unique case (cfg_reg_t'(cfg.index))
                    REG_EDGES_IN_USE:
                    begin
                        eu_reg <= (cfg.data > EDGES_W'(MAX_EDGES))
                                  ? EDGES_W'(MAX_EDGES) : cfg.data;
                    end
                    REG_EXCLUDED_IN_USE:
                    begin
                        xu_reg <= (cfg.data[EXCL_CNT_W-1:0] > EXCL_CNT_W'(MAX_EXCLUDED))
                                  ? EXCL_CNT_W'(MAX_EXCLUDED) : cfg.data[EXCL_CNT_W-1:0];
                    end
                    REG_DIRECTED_MODE:
                    begin
                        dir_reg <= cfg.data[0];
                    end
                    default:
                    begin
                        dir_reg <= dir_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ia_reg      <= ia_next;
        ib_reg      <= ib_next;
        sn_reg      <= sn_next;
        tn_reg      <= tn_next;
        sa_reg      <= sa_next;
        ta_reg      <= ta_next;
        sb_reg      <= sb_next;
        tb_reg      <= tb_next;
        cand_reg    <= cand_next;
        xidx_reg    <= xidx_next;
        outcome_reg <= outcome_next;
        rs_reg      <= rs_next;
        rt_reg      <= rt_next;
        if (state_reg == S_RESP && res_free)
        begin
            res_outcome_reg <= outcome_reg;
            res_src_reg     <= rs_reg;
            res_tgt_reg     <= rt_reg;
            res_same_reg    <= cnt_same_next;
            res_self_reg    <= cnt_self_next;
            res_dup_reg     <= cnt_dup_next;
            res_rev_reg     <= cnt_rev_next;
            res_excl_reg    <= cnt_excl_next;
        end
    end

    // result word
    assign cfg.ready                      = 1'b1;
    assign result.valid                   = res_valid_reg;
    assign result.outcome                 = res_outcome_reg;
    assign result.edge_source             = res_src_reg;
    assign result.edge_target             = res_tgt_reg;
    assign result.count_same_edge         = res_same_reg;
    assign result.count_self_loop         = res_self_reg;
    assign result.count_duplicate         = res_dup_reg;
    assign result.count_reverse_duplicate = res_rev_reg;
    assign result.count_excluded          = res_excl_reg;

endmodule
